FILE: rtl/hrfl_pkg.sv
// ----------------------------------------------------------------------------
// hrfl_pkg
// Shared types, character codes and helpers for the hex record flash loader.
// ----------------------------------------------------------------------------
package hrfl_pkg;

  // Sizing that does not vary
  localparam int MAX_ITEMS  = 64;
  localparam int JOBQ_DEPTH = 2;
  localparam int IDX_W      = 6;   // buffer index, largest buffer is 64 bytes
  localparam int CNT_W      = 7;   // counts up to MAX_ITEMS

  // Characters
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_BAD   = 8'h58;
  localparam logic [7:0] CH_UNK   = 8'h3F;
  localparam logic [7:0] CH_OK    = 8'h2E;

  // Record types
  localparam logic [7:0] REC_DATA  = 8'h00;
  localparam logic [7:0] REC_EOF   = 8'h01;
  localparam logic [7:0] REC_START = 8'h03;
  localparam logic [7:0] REC_ERASE = 8'h04;

  // First byte of the jump written at address 0
  localparam logic [7:0] JUMP_OPCODE = 8'h02;

  // Characters sent per request
  localparam logic [2:0] TX_ECHO   = 3'd1;
  localparam logic [2:0] TX_STATUS = 3'd2;
  localparam logic [2:0] TX_ID     = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEN, PH_AHI, PH_ALO, PH_TYPE, PH_DATA, PH_SUM
  } phase_t;

  typedef enum logic {BK_IDLE, BK_RUN} back_state_t;

  typedef enum logic [1:0] {OP_NONE, OP_WRITE, OP_ERASE} flash_op_t;

  typedef enum logic [1:0] {JM_NONE, JM_WRITE, JM_ERASE} job_mode_t;

  // One classified request, handed from the parser to the sequencer
  typedef struct packed {
    logic [7:0]       echo;
    logic [7:0]       status;
    logic             id_chars;
    logic [2:0]       tx_n;
    job_mode_t        mode;
    logic [15:0]      base;
    logic [IDX_W-1:0] j0;
    logic [CNT_W-1:0] op_n;
    logic [IDX_W-1:0] last_idx;
  } job_t;

  // Data buffer write port
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } buf_wr_t;

  // Hex digit to nibble: letters get 9 added, low four bits kept
  function automatic logic [3:0] to_nibble(input logic [7:0] c);
    logic [3:0] adj;
    adj = c[6] ? 4'd9 : 4'd0;
    return c[3:0] + adj;
  endfunction

endpackage

FILE: rtl/hrfl_front.sv
// ----------------------------------------------------------------------------
// hrfl_front
// Record parser: takes characters, tracks the record fields, fills the data
// buffer and classifies each request into a job for the sequencer.
// ----------------------------------------------------------------------------
module hrfl_front #(
  parameter int BOOT_START   = 15872,
  parameter int BUFFER_DEPTH = 64,
  parameter int ERASE_PAGES  = 31
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  logic [7:0]      in_rx_char,
  input  logic            job_full,
  output logic            job_push,
  output hrfl_pkg::job_t  job,
  output hrfl_pkg::buf_wr_t buf_wr,
  input  logic            buf_release
);
  import hrfl_pkg::*;

  localparam logic [15:0]      BOOT_W    = 16'(BOOT_START);
  localparam logic [7:0]       DEPTH_W   = 8'(BUFFER_DEPTH);
  localparam logic [CNT_W-1:0] ERASE_OPS = CNT_W'(ERASE_PAGES + 3);

  phase_t      phase_r, phase_nxt;
  logic        pend_r, pend_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic        lock_r, lock_nxt;

  logic        accept;
  logic        rec_active;
  logic        byte_done;
  logic [3:0]  nib;
  logic [7:0]  byte_v;
  logic [7:0]  sum_add;
  logic        bad;

  // Data record write count
  logic             below;
  logic [15:0]      room;
  logic [15:0]      len16;
  logic [15:0]      op_lo16;
  logic [16:0]      wrap17;
  logic [15:0]      op_hi16;
  logic [15:0]      opn16;
  logic [CNT_W-1:0] wr_n;
  logic [7:0]       j0_8;
  logic [CNT_W-1:0] tx7;
  logic [CNT_W-1:0] n_max;

  // Character decode
  assign in_full    = job_full || (lock_r && (phase_r == PH_DATA));
  assign accept     = in_push && !in_full;
  assign rec_active = phase_r inside {[PH_LEN:PH_SUM]};
  assign byte_done  = accept && rec_active && pend_r;
  assign nib        = to_nibble(in_rx_char);
  assign byte_v     = {hi_r, nib};
  assign sum_add    = sum_r + byte_v;
  assign bad        = (sum_add != 8'h00) || (len_r > DEPTH_W);

  // Writes below the boot region form one contiguous run of the record
  assign below   = addr_r < BOOT_W;
  assign room    = BOOT_W - addr_r;
  assign len16   = {8'h00, len_r};
  assign op_lo16 = (len16 < room) ? len16 : room;
  assign wrap17  = {1'b0, addr_r} + {9'h000, len_r};
  assign op_hi16 = wrap17[16] ? wrap17[15:0] : 16'h0000;
  assign opn16   = below ? op_lo16 : op_hi16;
  assign wr_n    = opn16[CNT_W-1:0];
  assign j0_8    = below ? 8'h00 : (len_r - {1'b0, wr_n});

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    hi_nxt    = hi_r;
    len_nxt   = len_r;
    addr_nxt  = addr_r;
    type_nxt  = type_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    lock_nxt  = lock_r;
    if (buf_release) begin
      lock_nxt = 1'b0;
    end
    if (job_push && (job.mode == JM_WRITE)) begin
      lock_nxt = 1'b1;
    end
    if (accept) begin
      if (!rec_active) begin
        phase_nxt = PH_IDLE;
        if (in_rx_char == CH_COLON) begin
          phase_nxt = PH_LEN;
          pend_nxt  = 1'b0;
          sum_nxt   = 8'h00;
          cnt_nxt   = 8'h00;
        end
      end else if (!pend_r) begin
        hi_nxt   = nib;
        pend_nxt = 1'b1;
      end else begin
        pend_nxt = 1'b0;
        sum_nxt  = sum_add;
        case (phase_r)
          PH_LEN: begin
            len_nxt   = byte_v;
            phase_nxt = PH_AHI;
          end
          PH_AHI: begin
            addr_nxt  = {byte_v, 8'h00};
            phase_nxt = PH_ALO;
          end
          PH_ALO: begin
            addr_nxt  = addr_r | {8'h00, byte_v};
            phase_nxt = PH_TYPE;
          end
          PH_TYPE: begin
            type_nxt  = byte_v;
            cnt_nxt   = 8'h00;
            phase_nxt = (len_r != 8'h00) ? PH_DATA : PH_SUM;
          end
          PH_DATA: begin
            cnt_nxt = cnt_r + 8'd1;
            if ((cnt_r + 8'd1) == len_r) begin
              phase_nxt = PH_SUM;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Job and buffer write
  always_comb begin
    job_push    = accept;
    buf_wr.we   = byte_done && (phase_r == PH_DATA) && (cnt_r < DEPTH_W);
    buf_wr.addr = cnt_r[IDX_W-1:0];
    buf_wr.data = byte_v;

    job          = '0;
    job.echo     = in_rx_char;
    job.status   = CH_OK;
    job.tx_n     = TX_ECHO;
    job.mode     = JM_NONE;
    job.base     = addr_r;
    job.j0       = j0_8[IDX_W-1:0];
    job.op_n     = '0;
    job.id_chars = 1'b0;

    // Checksum byte ends the record
    if (byte_done && (phase_r == PH_SUM)) begin
      job.tx_n = TX_STATUS;
      if (bad) begin
        job.status = CH_BAD;
      end else begin
        case (type_r)
          REC_DATA: begin
            if (wr_n != '0) begin
              job.mode = JM_WRITE;
              job.op_n = wr_n;
            end
          end
          REC_ERASE: begin
            job.mode = JM_ERASE;
            job.op_n = ERASE_OPS;
          end
          REC_START: begin
            job.id_chars = 1'b1;
            job.tx_n     = TX_ID;
          end
          REC_EOF: begin
            job.mode = JM_NONE;
          end
          default: begin
            job.status = CH_UNK;
          end
        endcase
      end
    end

    tx7          = {{(CNT_W-3){1'b0}}, job.tx_n};
    n_max        = (job.op_n > tx7) ? job.op_n : tx7;
    job.last_idx = IDX_W'(n_max - CNT_W'(1));
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pend_r  <= 1'b0;
      hi_r    <= 4'h0;
      len_r   <= 8'h00;
      addr_r  <= 16'h0000;
      type_r  <= 8'h00;
      sum_r   <= 8'h00;
      cnt_r   <= 8'h00;
      lock_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      hi_r    <= hi_nxt;
      len_r   <= len_nxt;
      addr_r  <= addr_nxt;
      type_r  <= type_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      lock_r  <= lock_nxt;
    end
  end

endmodule

FILE: rtl/hrfl_jobq.sv
// ----------------------------------------------------------------------------
// hrfl_jobq
// Short job queue between the parser and the sequencer.
// ----------------------------------------------------------------------------
module hrfl_jobq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hrfl_pkg::job_t din,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output hrfl_pkg::job_t dout
);
  import hrfl_pkg::*;

  localparam int PW = $clog2(JOBQ_DEPTH);

  job_t                         q_r [JOBQ_DEPTH];
  logic [PW-1:0]                wp_r, wp_nxt;
  logic [PW-1:0]                rp_r, rp_nxt;
  logic [$clog2(JOBQ_DEPTH+1)-1:0] cnt_r, cnt_nxt;
  logic                         do_push;
  logic                         do_pop;

  assign full    = (cnt_r == ($bits(cnt_r))'(JOBQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = q_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and count update
  always_comb begin
    wp_nxt  = do_push ? wp_r + PW'(1) : wp_r;
    rp_nxt  = do_pop  ? rp_r + PW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= din;
    end
  end

endmodule

FILE: rtl/hrfl_back.sv
// ----------------------------------------------------------------------------
// hrfl_back
// Sequencer: owns the data buffer and turns each job into result requests,
// one per cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module hrfl_back #(
  parameter int BOOT_START   = 15872,
  parameter int PAGE_SIZE    = 512,
  parameter int BUFFER_DEPTH = 64,
  parameter int ERASE_PAGES  = 31
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_empty,
  input  hrfl_pkg::job_t    job_head,
  output logic              job_pop,
  input  hrfl_pkg::buf_wr_t buf_wr,
  output logic              buf_release,
  output logic              out_empty,
  input  logic              out_pop,
  output logic              out_tx_valid,
  output logic [7:0]        out_tx_char,
  output logic [1:0]        out_flash_op,
  output logic [15:0]       out_flash_addr,
  output logic [7:0]        out_flash_data,
  output logic              out_last
);
  import hrfl_pkg::*;

  localparam int          AW        = $clog2(BUFFER_DEPTH);
  localparam logic [15:0] ERASE_TOP = 16'((ERASE_PAGES - 1) * PAGE_SIZE);
  localparam logic [15:0] PAGE_W    = 16'(PAGE_SIZE);
  localparam logic [15:0] RELOC     = 16'(BOOT_START - 3);
  localparam logic [IDX_W-1:0] EP   = IDX_W'(ERASE_PAGES);
  localparam logic [7:0]  BOOT_HI   = 8'((BOOT_START >> 8) & 255);
  localparam logic [7:0]  BOOT_LO   = 8'(BOOT_START & 255);

  back_state_t      state_r, state_nxt;
  job_t             job_r;
  logic [IDX_W-1:0] k_r;
  logic [IDX_W-1:0] j_r;
  logic [15:0]      wa_r;
  logic [15:0]      ea_r;

  logic [7:0]       mem [BUFFER_DEPTH];
  logic [7:0]       rd_r;

  // Output stage
  logic             s1_valid_r;
  logic             s1_tx_valid_r;
  logic [7:0]       s1_tx_char_r;
  flash_op_t        s1_op_r;
  logic [15:0]      s1_addr_r;
  logic             s1_use_buf_r;
  logic [7:0]       s1_cdata_r;
  logic             s1_last_r;

  // Current item
  logic             stall;
  logic             adv;
  logic             it_tx_valid;
  logic [7:0]       it_tx_char;
  flash_op_t        it_op;
  logic [15:0]      it_addr;
  logic             it_use_buf;
  logic [7:0]       it_cdata;
  logic             it_last;
  logic             k_in_ops;
  logic [IDX_W-1:0] ek;

  assign stall    = s1_valid_r && !out_pop;
  assign adv      = (state_r == BK_RUN) && !stall;
  assign k_in_ops = {1'b0, k_r} < job_r.op_n;
  assign ek       = k_r - EP;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!job_empty) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (adv && it_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Item for index k and control outputs
  always_comb begin
    job_pop     = (state_r == BK_IDLE) && !job_empty;
    it_last     = (k_r == job_r.last_idx);
    buf_release = adv && it_last && (job_r.mode == JM_WRITE);

    // Transmit part
    it_tx_valid = {4'h0, k_r} < {{(CNT_W-3){1'b0}}, job_r.tx_n};
    if (k_r == '0) begin
      it_tx_char = job_r.echo;
    end else if (!job_r.id_chars) begin
      it_tx_char = job_r.status;
    end else begin
      case (k_r)
        IDX_W'(1): it_tx_char = CH_THREE;
        IDX_W'(2): it_tx_char = CH_EIGHT;
        IDX_W'(3): it_tx_char = CH_C;
        default:   it_tx_char = job_r.status;
      endcase
    end
    if (!it_tx_valid) begin
      it_tx_char = 8'h00;
    end

    // Flash part
    it_op      = OP_NONE;
    it_addr    = 16'h0000;
    it_use_buf = 1'b0;
    it_cdata   = 8'h00;
    case (job_r.mode)
      JM_WRITE: begin
        if (k_in_ops) begin
          it_op      = OP_WRITE;
          it_addr    = (wa_r < 16'd3) ? wa_r + RELOC : wa_r;
          it_use_buf = 1'b1;
        end
      end
      JM_ERASE: begin
        if (k_r < EP) begin
          it_op   = OP_ERASE;
          it_addr = ea_r;
        end else if (k_in_ops) begin
          it_op   = OP_WRITE;
          it_addr = {14'h0000, ek[1:0]};
          case (ek[1:0])
            2'd0:    it_cdata = JUMP_OPCODE;
            2'd1:    it_cdata = BOOT_HI;
            default: it_cdata = BOOT_LO;
          endcase
        end
      end
      default: begin
        it_op = OP_NONE;
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job_head;
      k_r   <= '0;
      j_r   <= job_head.j0;
      wa_r  <= job_head.base + {{(16-IDX_W){1'b0}}, job_head.j0};
      ea_r  <= ERASE_TOP;
    end else if (adv) begin
      k_r  <= k_r + IDX_W'(1);
      j_r  <= j_r + IDX_W'(1);
      wa_r <= wa_r + 16'd1;
      ea_r <= ea_r - PAGE_W;
    end
  end

  // Data buffer
  always_ff @(posedge clk) begin
    if (buf_wr.we) begin
      mem[buf_wr.addr[AW-1:0]] <= buf_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r <= mem[j_r[AW-1:0]];
    end
  end

  // Output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= 1'b1;
    end else if (out_pop) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tx_valid_r <= it_tx_valid;
      s1_tx_char_r  <= it_tx_char;
      s1_op_r       <= it_op;
      s1_addr_r     <= it_addr;
      s1_use_buf_r  <= it_use_buf;
      s1_cdata_r    <= it_cdata;
      s1_last_r     <= it_last;
    end
  end

  assign out_empty      = !s1_valid_r;
  assign out_tx_valid   = s1_tx_valid_r;
  assign out_tx_char    = s1_tx_char_r;
  assign out_flash_op   = s1_op_r;
  assign out_flash_addr = s1_addr_r;
  assign out_flash_data = s1_use_buf_r ? rd_r : s1_cdata_r;
  assign out_last       = s1_last_r;

endmodule

FILE: rtl/hex_record_flash_loader_unit.sv
// ----------------------------------------------------------------------------
// hex_record_flash_loader_unit
// Hex record loader: echoes serial characters, parses records and issues
// flash writes, page erases and status characters.
// ----------------------------------------------------------------------------
// Path: the first result of a request passes the job queue, the job register and the
//   output register after acceptance when the sequencer is free.
// Throughput: the sequencer loads a request, then gives its N results (1 to 64),
//   one result per cycle unless the output stalls; a record end drains up to 64.
// Data characters are held off while a data record still reads the buffer.
// Reset: synchronous, active low; clears control state, buffer not cleared.
module hex_record_flash_loader_unit #(
  parameter int BOOT_START   = 15872,
  parameter int PAGE_SIZE    = 512,
  parameter int BUFFER_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_char,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_char,
  output logic [1:0]  out_flash_op,
  output logic [15:0] out_flash_addr,
  output logic [7:0]  out_flash_data,
  output logic        out_last
);
  import hrfl_pkg::*;

  // Pages erased below the boot region, rounded up and capped
  localparam int ERASE_PAGES_RAW = (BOOT_START + PAGE_SIZE - 1) / PAGE_SIZE;
  localparam int ERASE_PAGES     = (ERASE_PAGES_RAW > MAX_ITEMS - 3) ?
                                   MAX_ITEMS - 3 : ERASE_PAGES_RAW;

  job_t    job_in;
  job_t    job_head;
  logic    job_push;
  logic    job_full;
  logic    job_pop;
  logic    job_empty;
  buf_wr_t buf_wr;
  logic    buf_release;

  hrfl_front #(
    .BOOT_START   (BOOT_START),
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .ERASE_PAGES  (ERASE_PAGES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_rx_char  (in_rx_char),
    .job_full    (job_full),
    .job_push    (job_push),
    .job         (job_in),
    .buf_wr      (buf_wr),
    .buf_release (buf_release)
  );

  hrfl_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .empty (job_empty),
    .dout  (job_head)
  );

  hrfl_back #(
    .BOOT_START   (BOOT_START),
    .PAGE_SIZE    (PAGE_SIZE),
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .ERASE_PAGES  (ERASE_PAGES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_empty      (job_empty),
    .job_head       (job_head),
    .job_pop        (job_pop),
    .buf_wr         (buf_wr),
    .buf_release    (buf_release),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_tx_valid   (out_tx_valid),
    .out_tx_char    (out_tx_char),
    .out_flash_op   (out_flash_op),
    .out_flash_addr (out_flash_addr),
    .out_flash_data (out_flash_data),
    .out_last       (out_last)
  );

endmodule

FILE: rtl/hrfl_checker.sv
// ----------------------------------------------------------------------------
// hrfl_checker
// Port-level checks on the result requests of the loader, bound to the top.
// ----------------------------------------------------------------------------
module hrfl_checker #(
  parameter int BOOT_START = 15872
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_tx_valid,
  input logic [7:0]  out_tx_char,
  input logic [1:0]  out_flash_op,
  input logic [15:0] out_flash_addr,
  input logic [7:0]  out_flash_data
);
  import hrfl_pkg::*;

  localparam logic [15:0] BOOT_W = 16'(BOOT_START);

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result offered right after reset");

  // Every request carries a character or a flash operation
  a_not_blank: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_tx_valid || (out_flash_op != OP_NONE)))
    else $error("result request carries nothing");

  a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_tx_valid) |-> (out_tx_char == 8'h00))
    else $error("character set without valid");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_flash_op != OP_WRITE)) |-> (out_flash_data == 8'h00))
    else $error("flash data set without a write");

  // Writes never reach the boot region
  a_boot_safe: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_flash_op == OP_WRITE)) |-> (out_flash_addr < BOOT_W))
    else $error("flash write into boot region");

endmodule

bind hex_record_flash_loader_unit hrfl_checker #(
  .BOOT_START (BOOT_START)
) u_hrfl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_empty      (out_empty),
  .out_tx_valid   (out_tx_valid),
  .out_tx_char    (out_tx_char),
  .out_flash_op   (out_flash_op),
  .out_flash_addr (out_flash_addr),
  .out_flash_data (out_flash_data)
);
